FILE: hdl/mcas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcas_pkg: shared types and constants for the alarm scheduler
// Field widths, function and register codes, FSM states and the word that
// moves between ring cells.
// ----------------------------------------------------------------------------
package mcas_pkg;

   localparam int CLIENTS_DEF = 32;
   localparam int MASK_W      = 32;
   localparam int TIME_W      = 64;
   localparam int MARGIN_W    = 16;
   localparam int ID_W        = 5;
   localparam int FUNC_W      = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 4;

   localparam logic [TIME_W-1:0] PROG_RESET    = 64'h0000_0000_ffff_ffff;
   localparam logic [TIME_W-1:0] MAX_DUR_RESET = 64'h0000_0000_ffff_ffff;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ARM_ABS = 2'd0,
      FUNC_ARM_REL = 2'd1,
      FUNC_RESCAN  = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef enum logic {
      REG_ERROR_MARGIN = 1'b0,
      REG_MAX_DURATION = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ARM,
      ST_SCAN,
      ST_DONE
   } state_type;

   // word held by one ring cell
   typedef struct packed {
      logic              valid;
      logic [TIME_W-1:0] match;
   } cell_word_type;

   // arm write into one cell: set marks valid and stores match, else clears valid
   typedef struct packed {
      logic              load;
      logic              set;
      logic [TIME_W-1:0] match;
   } cell_write_type;

endpackage
`default_nettype wire

FILE: hdl/mcas_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcas_cell: one client slot of the ring
// Holds valid bit and match tick; rotates to its neighbor during a rescan.
// ----------------------------------------------------------------------------
module mcas_cell
   import mcas_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           shift,
   input  wire cell_word_type  shift_in,
   input  wire cell_write_type wr,
   output cell_word_type       word
);

   logic              valid_ff, valid_in;
   logic [TIME_W-1:0] match_ff, match_in;

   always_comb begin
      valid_in = valid_ff;
      match_in = match_ff;
      if (shift) begin
         valid_in = shift_in.valid;
         match_in = shift_in.match;
      end else if (wr.load) begin
         valid_in = wr.set;
         if (wr.set) begin
            match_in = wr.match;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // match is only looked at while valid
   always_ff @(posedge clock) begin
      match_ff <= match_in;
   end

   assign word.valid = valid_ff;
   assign word.match = match_ff;

endmodule
`default_nettype wire

FILE: hdl/mcas_pick.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcas_pick: head-of-ring compare unit
// Due check against now + margin and nearest-match tracking by wrap distance.
// ----------------------------------------------------------------------------
module mcas_pick
   import mcas_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                init,
   input  wire logic                step,
   input  wire logic [TIME_W-1:0]   now,
   input  wire logic [MARGIN_W-1:0] margin,
   input  wire logic [TIME_W-1:0]   max_duration,
   input  wire cell_word_type       head,
   output logic      [TIME_W-1:0]   thr,
   output logic                     expire,
   output logic      [TIME_W-1:0]   best
);

   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] thr_ff, thr_in;
   logic [TIME_W-1:0] best_ff, best_in;
   logic [TIME_W-1:0] dist_ff, dist_in;
   logic [TIME_W-1:0] head_dist;
   logic              head_due;

   assign head_dist = head.match - now_ff;
   assign head_due  = thr_ff >= head.match;
   assign expire    = step & head.valid & head_due;

   always_comb begin
      now_in  = now_ff;
      thr_in  = thr_ff;
      best_in = best_ff;
      dist_in = dist_ff;
      if (init) begin
         now_in  = now;
         thr_in  = now + TIME_W'(margin);
         best_in = max_duration;
         dist_in = max_duration - now;
      end else if (step && head.valid && !head_due && (dist_ff > head_dist)) begin
         best_in = head.match;
         dist_in = head_dist;
      end
   end

   always_ff @(posedge clock) begin
      now_ff  <= now_in;
      thr_ff  <= thr_in;
      best_ff <= best_in;
      dist_ff <= dist_in;
   end

   assign thr  = thr_ff;
   assign best = best_ff;

endmodule
`default_nettype wire

FILE: hdl/multi_client_alarm_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_client_alarm_scheduler: per-client alarm store with nearest-match pick
// Arms client alarms, expires due ones and programs the nearest match tick.
// ----------------------------------------------------------------------------
// Usage: issue a word with start while busy is low. Every word yields exactly
// one result, shown on the rsp_ ports for one cycle with rsp_valid; the
// receiver must take it then, there is no back-pressure. An arm (func 0/1)
// passes through the ARM state, a rescan (func 2) through SCAN and DONE,
// and the unused code (func 3) is answered from idle. busy is low again in the
// cycle the result is shown, so the next word can start there. The rescan
// length comes from the ring: client slots sit in a row of cells that rotates
// one slot per cycle past a single compare unit at the head, so a rescan
// rotates every slot past the head once, then programs the picked match and
// shows the result on the ports. Configuration (error margin at 0x0, max
// duration at 0x8, both 64-bit APB words) may only be written while idle.
// ----------------------------------------------------------------------------
module multi_client_alarm_scheduler
   import mcas_pkg::*;
#(
   parameter int CLIENTS = CLIENTS_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // command channel
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [FUNC_W-1:0]     req_func,
   input  wire logic [ID_W-1:0]       req_client_id,
   input  wire logic [TIME_W-1:0]     req_value,
   input  wire logic [TIME_W-1:0]     req_now,
   // result channel
   output logic                       rsp_valid,
   output logic                       rsp_wake_needed,
   output logic                       rsp_historic,
   output logic [MASK_W-1:0]          rsp_expired_mask,
   output logic [TIME_W-1:0]          rsp_hw_match,
   output logic                       rsp_hw_updated,
   output logic                       rsp_write_order,
   // APB configuration port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int CIW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

   // ---------------------------------------------------------------- CSRs
   logic [MARGIN_W-1:0] margin_ff, margin_in;
   logic [TIME_W-1:0]   max_dur_ff, max_dur_in;
   logic                csr_write;

   assign pready    = 1'b1;
   // byte address bit 3 picks the register; lower bits are don't-care
   assign csr_write = psel & penable & pwrite;

   always_comb begin
      margin_in  = margin_ff;
      max_dur_in = max_dur_ff;
      if (csr_write) begin
         unique case (reg_index_type'(paddr[3]))
            REG_ERROR_MARGIN: margin_in  = pwdata[MARGIN_W-1:0];
            REG_MAX_DURATION: max_dur_in = pwdata;
            default:          margin_in  = margin_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(paddr[3]))
         REG_ERROR_MARGIN: prdata = CSR_DATA_W'(margin_ff);
         REG_MAX_DURATION: prdata = max_dur_ff;
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff  <= '0;
         max_dur_ff <= MAX_DUR_RESET;
      end else begin
         margin_ff  <= margin_in;
         max_dur_ff <= max_dur_in;
      end
   end

   // ---------------------------------------------------------------- control
   state_type           state_ff, state_in;
   logic [CIW-1:0]      cnt_ff, cnt_in;
   logic [CLIENTS-1:0]  expired_ff, expired_in;
   logic [TIME_W-1:0]   prog_ff, prog_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                wake_ff, wake_in;
   logic                hist_ff, hist_in;
   logic                upd_ff, upd_in;
   logic                order_ff, order_in;

   // latched arm request
   logic [TIME_W-1:0]   arm_match_ff, arm_match_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic                in_range_ff, in_range_in;

   logic                arm_latch;
   logic                arm_write;
   logic                due_arm;
   logic                pick_init;
   logic                pick_step;
   logic                shift;
   logic                expire;
   logic [TIME_W-1:0]   thr;
   logic [TIME_W-1:0]   best;

   cell_word_type       words [CLIENTS];
   cell_word_type       ret_word;
   logic [CLIENTS-1:0]  valid_vec;

   // ---------------------------------------------------------------- ring
   // cell 0 is the head; a rescan rotates every slot down by one per cycle
   // and feeds the head word back into the tail with its valid bit cleared
   // if it expired. After CLIENTS shifts every slot is home again.
   assign ret_word.valid = words[0].valid & ~expire;
   assign ret_word.match = words[0].match;

   for (genvar i = 0; i < CLIENTS; i++) begin : g_cell
      cell_word_type  nbr;
      cell_write_type wr;

      if (i == CLIENTS - 1) begin : g_tail
         assign nbr = ret_word;
      end else begin : g_body
         assign nbr = words[i+1];
      end

      assign wr.load  = arm_write & (id_ff == ID_W'(i));
      assign wr.set   = ~due_arm;
      assign wr.match = arm_match_ff;

      mcas_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (shift),
         .shift_in (nbr),
         .wr       (wr),
         .word     (words[i])
      );

      assign valid_vec[i] = words[i].valid;
   end

   mcas_pick u_pick (
      .clock        (clock),
      .init         (pick_init),
      .step         (pick_step),
      .now          (req_now),
      .margin       (margin_ff),
      .max_duration (max_dur_ff),
      .head         (words[0]),
      .thr          (thr),
      .expire       (expire),
      .best         (best)
   );

   // thr holds now + margin from the accept cycle
   assign due_arm = thr >= arm_match_ff;

   // ---------------------------------------------------------------- FSM
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      expired_in   = expired_ff;
      prog_in      = prog_ff;
      rsp_valid_in = 1'b0;
      wake_in      = 1'b0;
      hist_in      = 1'b0;
      upd_in       = 1'b0;
      order_in     = 1'b0;
      arm_latch    = 1'b0;
      arm_write    = 1'b0;
      pick_init    = 1'b0;
      pick_step    = 1'b0;
      shift        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               expired_in = '0;
               cnt_in     = '0;
               unique case (func_type'(req_func)) inside
                  FUNC_ARM_ABS, FUNC_ARM_REL: begin
                     arm_latch = 1'b1;
                     pick_init = 1'b1;
                     state_in  = ST_ARM;
                  end
                  FUNC_RESCAN: begin
                     pick_init = 1'b1;
                     state_in  = ST_SCAN;
                  end
                  default: begin
                     // unused code: empty result straight away
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_ARM: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (in_range_ff) begin
               arm_write = 1'b1;
               hist_in   = due_arm;
               // already due: wake only if a live alarm got dropped
               wake_in   = due_arm ? valid_vec[id_ff[CIW-1:0]] : 1'b1;
            end
         end
         ST_SCAN: begin
            pick_step = 1'b1;
            shift     = 1'b1;
            if (expire) begin
               expired_in[cnt_ff] = 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CIW'(CLIENTS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            hist_in      = |expired_ff;
            state_in     = ST_IDLE;
            if (best != prog_ff) begin
               upd_in   = 1'b1;
               order_in = ~(best > prog_ff);
               prog_in  = best;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      arm_match_in = arm_match_ff;
      id_in        = id_ff;
      in_range_in  = in_range_ff;
      if (arm_latch) begin
         arm_match_in = (func_type'(req_func) == FUNC_ARM_REL) ? (req_value + req_now)
                                                               : req_value;
         id_in        = req_client_id;
         in_range_in  = 32'(req_client_id) < 32'(CLIENTS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         prog_ff      <= PROG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         prog_ff      <= prog_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      expired_ff   <= expired_in;
      wake_ff      <= wake_in;
      hist_ff      <= hist_in;
      upd_ff       <= upd_in;
      order_ff     <= order_in;
      arm_match_ff <= arm_match_in;
      id_ff        <= id_in;
      in_range_ff  <= in_range_in;
   end

   // ---------------------------------------------------------------- outputs
   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_wake_needed  = wake_ff;
   assign rsp_historic     = hist_ff;
   assign rsp_expired_mask = MASK_W'(expired_ff);
   assign rsp_hw_match     = prog_ff;
   assign rsp_hw_updated   = upd_ff;
   assign rsp_write_order  = order_ff;

endmodule
`default_nettype wire

FILE: test/multi_client_alarm_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_client_alarm_scheduler_tb: self-checking bench for the alarm scheduler
// Drives arm, rescan and unused command words in random bursts with random
// gaps, predicts every result word from a local copy of the client store and
// compares each strobed result field by field. Both CSRs are swept through
// several settings, extremes included, between drained phases.
// ----------------------------------------------------------------------------
module multi_client_alarm_scheduler_tb
   import mcas_pkg::*;
();

   localparam int CLIENTS    = CLIENTS_DEF;
   localparam int IDLE_LIMIT = 1000;   // cycles with no traffic before giving up
   localparam int SETTLE     = CLIENTS + 4;

   // one command word as it goes onto the req_ ports
   typedef struct packed {
      func_type          func;
      logic [ID_W-1:0]   client_id;
      logic [TIME_W-1:0] value;
      logic [TIME_W-1:0] now;
   } alarm_command_type;

   // one result word as it should appear on the rsp_ ports
   typedef struct packed {
      logic              wake;
      logic              historic;
      logic [MASK_W-1:0] expired;
      logic [TIME_W-1:0] hw_match;
      logic              updated;
      logic              order;
   } alarm_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  start         = 1'b0;
   logic                  busy;
   func_type              req_func      = FUNC_ARM_ABS;
   logic [ID_W-1:0]       req_client_id = '0;
   logic [TIME_W-1:0]     req_value     = '0;
   logic [TIME_W-1:0]     req_now       = '0;

   logic                  rsp_valid;
   logic                  rsp_wake_needed;
   logic                  rsp_historic;
   logic [MASK_W-1:0]     rsp_expired_mask;
   logic [TIME_W-1:0]     rsp_hw_match;
   logic                  rsp_hw_updated;
   logic                  rsp_write_order;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   multi_client_alarm_scheduler #(.CLIENTS(CLIENTS)) DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_client_id    (req_client_id),
      .req_value        (req_value),
      .req_now          (req_now),
      .rsp_valid        (rsp_valid),
      .rsp_wake_needed  (rsp_wake_needed),
      .rsp_historic     (rsp_historic),
      .rsp_expired_mask (rsp_expired_mask),
      .rsp_hw_match     (rsp_hw_match),
      .rsp_hw_updated   (rsp_hw_updated),
      .rsp_write_order  (rsp_write_order),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Shadow of the scheduler: CSRs, per-client store and programmed match.
   // Updated in acceptance order by the driver, CSRs at their write edge.
   // ------------------------------------------------------------------------
   logic [MARGIN_W-1:0] margin_shadow   = '0;
   logic [TIME_W-1:0]   maxdur_shadow   = MAX_DUR_RESET;
   logic [MASK_W-1:0]   armed_mask      = '0;
   logic [TIME_W-1:0]   client_deadline [CLIENTS];
   logic [TIME_W-1:0]   hw_match_shadow = PROG_RESET;

   initial begin
      for (int i = 0; i < CLIENTS; i++) client_deadline[i] = '0;
   end

   alarm_command_type commands_waiting[$];   // words not yet put on the bus
   alarm_outcome_type outcomes_due[$];       // results owed by the block, oldest first

   int            mismatches = 0;
   logic [63:0]   wall_tick  = '0;        // free-running time seen by random words

   // match is due once now plus the slack has reached it, all mod 2^64
   function automatic logic deadline_reached(logic [TIME_W-1:0] now_t,
                                             logic [TIME_W-1:0] match);
      logic [TIME_W-1:0] horizon;
      horizon = now_t + {{(TIME_W-MARGIN_W){1'b0}}, margin_shadow};
      return horizon >= match;
   endfunction

   function automatic alarm_outcome_type next_alarm_outcome(func_type f,
                                                           logic [ID_W-1:0] id,
                                                           logic [TIME_W-1:0] v,
                                                           logic [TIME_W-1:0] n);
      alarm_outcome_type o;
      logic [TIME_W-1:0] match;
      logic [TIME_W-1:0] best;
      o = '0;
      case (f)
         FUNC_ARM_ABS, FUNC_ARM_REL: begin
            match = (f == FUNC_ARM_REL) ? v + n : v;
            if (deadline_reached(n, match)) begin
               // already due: drop the client, wake only if it was live
               o.historic     = 1'b1;
               o.wake         = armed_mask[id];
               armed_mask[id] = 1'b0;
            end else begin
               armed_mask[id]      = 1'b1;
               client_deadline[id] = match;
               o.wake              = 1'b1;
            end
         end
         FUNC_RESCAN: begin
            best = maxdur_shadow;
            for (int i = 0; i < CLIENTS; i++) begin
               if (armed_mask[i]) begin
                  if (deadline_reached(n, client_deadline[i])) begin
                     o.expired[i]  = 1'b1;
                     armed_mask[i] = 1'b0;
                  end else if (best - n > client_deadline[i] - n) begin
                     // nearer by wrapping distance from now
                     best = client_deadline[i];
                  end
               end
            end
            o.historic = |o.expired;
            if (best != hw_match_shadow) begin
               o.order         = (best > hw_match_shadow) ? 1'b0 : 1'b1;
               hw_match_shadow = best;
               o.updated       = 1'b1;
            end
         end
         default: ;
      endcase
      o.hw_match = hw_match_shadow;
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: pops words from the pending queue, holds start until the word is
   // taken, then either chains the next word of the burst or idles a gap.
   // ------------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   function automatic int pick_burst();
      // mostly short bursts, now and then a long run with no idling at all
      return ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
   endfunction

   always @(posedge clock) begin : driver
      alarm_command_type cmd;
      if (!reset) begin
         if (start && !busy) begin
            outcomes_due.push_back(next_alarm_outcome(req_func, req_client_id,
                                                      req_value, req_now));
            if (burst_left > 0 && commands_waiting.size() > 0) begin
               cmd           = commands_waiting.pop_front();
               req_func      <= cmd.func;
               req_client_id <= cmd.client_id;
               req_value     <= cmd.value;
               req_now       <= cmd.now;
               burst_left    <= burst_left - 1;
            end else begin
               start    <= 1'b0;
               gap_left <= $urandom_range(0, 15);
            end
         end else if (!start) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (commands_waiting.size() > 0) begin
               cmd           = commands_waiting.pop_front();
               start         <= 1'b1;
               req_func      <= cmd.func;
               req_client_id <= cmd.client_id;
               req_value     <= cmd.value;
               req_now       <= cmd.now;
               burst_left    <= pick_burst() - 1;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: no back-pressure, so every strobed word is checked on the spot.
   // ------------------------------------------------------------------------
   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : monitor
      alarm_outcome_type want;
      if (!reset && rsp_valid) begin
         if (outcomes_due.size() == 0) begin
            $display("%0t: result word expected none actual hw_match %h",
                     $time, rsp_hw_match);
            mismatches++;
         end else begin
            want = outcomes_due.pop_front();
            check_field("wake_needed",  64'(want.wake),     64'(rsp_wake_needed));
            check_field("historic",     64'(want.historic), 64'(rsp_historic));
            check_field("expired_mask", 64'(want.expired),  64'(rsp_expired_mask));
            check_field("hw_match",     want.hw_match,      rsp_hw_match);
            check_field("hw_updated",   64'(want.updated),  64'(rsp_hw_updated));
            check_field("write_order",  64'(want.order),    64'(rsp_write_order));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: any accepted word, result or CSR access resets the count.
   // ------------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid || psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic queue_command(func_type f, logic [ID_W-1:0] id,
                                logic [TIME_W-1:0] v, logic [TIME_W-1:0] n);
      alarm_command_type cmd;
      cmd.func      = f;
      cmd.client_id = id;
      cmd.value     = v;
      cmd.now       = n;
      commands_waiting.push_back(cmd);
   endtask

   // setup cycle, access cycle; the register takes the data at the end of the access cycle
   task automatic write_csr(reg_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_ERROR_MARGIN) margin_shadow = data[MARGIN_W-1:0];
      else                         maxdur_shadow = data;
   endtask

   // sender holds off until every owed result is in, then lets a settling
   // period longer than a rescan pass so the block is surely idle
   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (commands_waiting.size() != 0 || start || outcomes_due.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Random words stay close to a slowly advancing wall time so that arms
   // land both inside and outside the slack and rescans find live clients;
   // occasional jumps and full-width values exercise every bit and the wrap.
   task automatic queue_random_commands(int count);
      int                r;
      func_type          f;
      logic [TIME_W-1:0] v;
      logic [TIME_W-1:0] n;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 3)      wall_tick = {$urandom, $urandom};
         else if (r < 6) wall_tick = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3000);
         else            wall_tick = wall_tick + $urandom_range(0, 400);
         n = wall_tick;
         r = $urandom_range(0, 99);
         if (r < 35)      f = FUNC_ARM_ABS;
         else if (r < 65) f = FUNC_ARM_REL;
         else if (r < 95) f = FUNC_RESCAN;
         else             f = FUNC_NONE;
         r = $urandom_range(0, 99);
         if (r < 10) begin
            v = {$urandom, $urandom};
         end else if (f == FUNC_ARM_REL) begin
            v = margin_shadow + $urandom_range(0, 4000) - 64'd1000;
         end else if (r < 20) begin
            v = n - $urandom_range(0, 200);
         end else begin
            v = n + margin_shadow + $urandom_range(0, 4000) - 64'd1000;
         end
         queue_command(f, ID_W'($urandom_range(0, CLIENTS - 1)), v, n);
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   logic [MARGIN_W-1:0] margin_set [5];
   logic [TIME_W-1:0]   maxdur_set [5];

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      // directed words at reset settings
      queue_command(FUNC_ARM_ABS, 5'd0,  64'd1000, 64'd0);       // armed
      queue_command(FUNC_ARM_ABS, 5'd0,  64'd10,   64'd100);     // due, was live
      queue_command(FUNC_ARM_ABS, 5'd0,  64'd10,   64'd100);     // due, was not live
      queue_command(FUNC_ARM_REL, 5'd31, 64'd500,  64'd200);
      queue_command(FUNC_ARM_REL, 5'd5,  64'd0,    64'd50);      // zero duration is due
      queue_command(FUNC_ARM_ABS, 5'd7,  64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
      queue_command(FUNC_ARM_ABS, 5'd12, 64'h1_0000_0000, 64'd0);
      queue_command(FUNC_RESCAN,  5'd0,  64'd0,    64'd100);     // nearest live client
      queue_command(FUNC_RESCAN,  5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 64'd800); // expires one
      queue_command(FUNC_NONE,    5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_command(FUNC_ARM_REL, 5'd3,  64'hFFFF_FFFF_FFFF_FF00, 64'h200); // sum wraps
      queue_command(FUNC_ARM_ABS, 5'd9,  64'h10, 64'hFFFF_FFFF_FFFF_FFF0);
      queue_command(FUNC_ARM_ABS, 5'd10, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_command(FUNC_ARM_REL, 5'd20, 64'h40, 64'hFFFF_FFFF_FFFF_FFF0); // match past wrap
      queue_command(FUNC_RESCAN,  5'd0,  64'd0, 64'hFFFF_FFFF_FFFF_FFF0);
      queue_command(FUNC_RESCAN,  5'd0,  64'd0, 64'hFFFF_FFFF_FFFF_FFFF); // expires all
      queue_command(FUNC_RESCAN,  5'd0,  64'd0, 64'd0);          // empty set, back to default
      queue_command(FUNC_NONE,    5'd0,  64'd0, 64'd0);
      wait_drained();

      margin_set[0] = 16'd0;            maxdur_set[0] = MAX_DUR_RESET;
      margin_set[1] = 16'hFFFF;         maxdur_set[1] = 64'hFFFF_FFFF_FFFF_FFFF;
      margin_set[2] = 16'd100;          maxdur_set[2] = 64'd0;
      margin_set[3] = MARGIN_W'($urandom);
      maxdur_set[3] = {$urandom, $urandom};
      margin_set[4] = 16'd0;            maxdur_set[4] = 64'd5000;

      for (int p = 0; p < 5; p++) begin
         write_csr(REG_ERROR_MARGIN, {48'd0, margin_set[p]});
         write_csr(REG_MAX_DURATION, maxdur_set[p]);
         @(posedge clock);
         #1;
         // chunks with a full drain between them
         for (int c = 0; c < 3; c++) begin
            queue_random_commands(60);
            wait_drained();
         end
      end

      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
